[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, gated off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[rtl/msda_pkg.sv]
// ----------------------------------------------------------------------------
// msda_pkg
// Constants, codes and field layout for the memset descriptor front end.
// ----------------------------------------------------------------------------
package msda_pkg;

   // Descriptor rules
   localparam int unsigned DESC_ALIGN    = 8;
   localparam int unsigned DESC_BYTES    = 32;
   localparam logic [7:0]  MEMSET_OPCODE = 8'd1;

   // Stream widths (packed fields padded to whole bytes)
   localparam int unsigned REQ_DATA_W = 216;
   localparam int unsigned RSP_DATA_W = 112;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BASE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LIMIT = 1'd1;

   // Device status codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_BUSY  = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   // Descriptor status and write-back codes
   localparam logic [1:0] DSTATE_PENDING = 2'd0;
   localparam logic [1:0] WB_NONE        = 2'd0;
   localparam logic [1:0] WB_OK          = 2'd1;
   localparam logic [1:0] WB_INVALID     = 2'd2;

   // Interrupt bit positions
   localparam int unsigned IRQ_DONE_IDX  = 0;
   localparam int unsigned IRQ_ERROR_IDX = 1;

   // Range check: [addr, addr+len) inside [base, limit), no wrap
   function automatic logic in_window(input logic [63:0] addr,
                                      input logic [63:0] len,
                                      input logic [63:0] base,
                                      input logic [63:0] limit);
      logic [64:0] sum;
      sum = {1'b0, addr} + {1'b0, len};
      return !sum[64] && (addr >= base) && (sum[63:0] <= limit);
   endfunction

endpackage

[rtl/memset_descriptor_accel_ctrl_top.sv]
// ----------------------------------------------------------------------------
// memset_descriptor_accel_ctrl_top
// Path: a req transfer is registered in the check stage, then in the state stage, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_tready does not stall; the status
// and interrupt registers update in the state stage, so each item sees the state left by the one before.
// Reset: synchronous, active high; status idle, interrupts clear, window
// registers zero, pipeline empty.
// ----------------------------------------------------------------------------
module memset_descriptor_accel_ctrl_top (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: start_req, reset_req, ack_done, ack_error, desc_addr,
   // desc_opcode, desc_flags, desc_spare, desc_state, desc_length,
   // desc_dest, desc_fill_byte, zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [msda_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: dev_status, irq_done, irq_error, fill_issue, fill_dest,
   // fill_length, fill_byte, desc_writeback, zero pad
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [msda_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msda_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [msda_pkg::CSR_DATA_W-1:0]      csr_data
);

`include "assert_macros.svh"

   // Unpacked request fields
   logic        req_start;
   logic        req_reset;
   logic        req_ack_done;
   logic        req_ack_error;
   logic [63:0] req_desc_addr;
   logic [7:0]  req_opcode;
   logic [15:0] req_flags;
   logic [15:0] req_spare;
   logic [1:0]  req_state;
   logic [31:0] req_length;
   logic [63:0] req_dest;
   logic [7:0]  req_fill_byte;

   assign req_start     = req_tdata[0];
   assign req_reset     = req_tdata[1];
   assign req_ack_done  = req_tdata[2];
   assign req_ack_error = req_tdata[3];
   assign req_desc_addr = req_tdata[67:4];
   assign req_opcode    = req_tdata[75:68];
   assign req_flags     = req_tdata[91:76];
   assign req_spare     = req_tdata[107:92];
   assign req_state     = req_tdata[109:108];
   assign req_length    = req_tdata[141:110];
   assign req_dest      = req_tdata[205:142];
   assign req_fill_byte = req_tdata[213:206];

   // Window registers
   logic [63:0] window_base_ff;
   logic [63:0] window_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_base_ff  <= '0;
         window_limit_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            msda_pkg::CSR_WINDOW_BASE:  window_base_ff  <= csr_data;
            msda_pkg::CSR_WINDOW_LIMIT: window_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Check stage: state-independent descriptor checks
   logic loc_ok;
   logic pay_ok;

   always_comb begin
      loc_ok = ((req_desc_addr % msda_pkg::DESC_ALIGN) == 64'd0) &&
               msda_pkg::in_window(req_desc_addr, 64'(msda_pkg::DESC_BYTES),
                                   window_base_ff, window_limit_ff);
      pay_ok = (req_opcode == msda_pkg::MEMSET_OPCODE) && (req_flags == 16'd0) &&
               (req_spare == 16'd0) && (req_state == msda_pkg::DSTATE_PENDING) &&
               (req_length != 32'd0) &&
               msda_pkg::in_window(req_dest, {32'd0, req_length},
                                   window_base_ff, window_limit_ff);
   end

   // Staged item
   logic        st_valid_ff;
   logic        st_start_ff;
   logic        st_reset_ff;
   logic        st_ack_done_ff;
   logic        st_ack_error_ff;
   logic        st_addr_zero_ff;
   logic        st_loc_ok_ff;
   logic        st_pay_ok_ff;
   logic [63:0] st_dest_ff;
   logic [31:0] st_length_ff;
   logic [7:0]  st_fill_byte_ff;

   logic advance;
   logic out_valid_ff;

   assign advance    = st_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !st_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else if (req_tready) begin
         st_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         st_start_ff     <= req_start;
         st_reset_ff     <= req_reset;
         st_ack_done_ff  <= req_ack_done;
         st_ack_error_ff <= req_ack_error;
         st_addr_zero_ff <= (req_desc_addr == 64'd0);
         st_loc_ok_ff    <= loc_ok;
         st_pay_ok_ff    <= pay_ok;
         st_dest_ff      <= req_dest;
         st_length_ff    <= req_length;
         st_fill_byte_ff <= req_fill_byte;
      end
   end

   // State stage: status, interrupts, fill command
   logic [1:0] status_ff;
   logic [1:0] status_in;
   logic [1:0] irq_ff;
   logic [1:0] irq_in;
   logic       issue;
   logic [1:0] wb;

   always_comb begin
      status_in = status_ff;
      irq_in    = irq_ff;
      issue     = 1'b0;
      wb        = msda_pkg::WB_NONE;
      if (st_reset_ff) begin
         status_in = msda_pkg::ST_IDLE;
         irq_in    = 2'b00;
      end else begin
         if (st_start_ff) begin
            if (status_ff != msda_pkg::ST_IDLE) begin
               status_in = msda_pkg::ST_ERROR;
               irq_in    = 2'b10;
            end else if (st_addr_zero_ff) begin
               status_in = msda_pkg::ST_DONE;
               irq_in    = 2'b01;
            end else if (!st_loc_ok_ff) begin
               status_in = msda_pkg::ST_ERROR;
               irq_in    = 2'b10;
            end else if (!st_pay_ok_ff) begin
               wb        = msda_pkg::WB_INVALID;
               status_in = msda_pkg::ST_ERROR;
               irq_in    = 2'b10;
            end else begin
               issue     = 1'b1;
               wb        = msda_pkg::WB_OK;
               status_in = msda_pkg::ST_DONE;
               irq_in    = 2'b01;
            end
         end
         // Acknowledge after start handling
         if (st_ack_done_ff) begin
            irq_in[msda_pkg::IRQ_DONE_IDX] = 1'b0;
         end
         if (st_ack_error_ff) begin
            irq_in[msda_pkg::IRQ_ERROR_IDX] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= msda_pkg::ST_IDLE;
         irq_ff    <= 2'b00;
      end else if (advance) begin
         status_ff <= status_in;
         irq_ff    <= irq_in;
      end
   end

   // Result register
   logic [msda_pkg::RSP_DATA_W-1:0] out_data_ff;
   logic [msda_pkg::RSP_DATA_W-1:0] out_data_in;

   always_comb begin
      out_data_in          = '0;
      out_data_in[1:0]     = status_in;
      out_data_in[2]       = irq_in[msda_pkg::IRQ_DONE_IDX];
      out_data_in[3]       = irq_in[msda_pkg::IRQ_ERROR_IDX];
      out_data_in[4]       = issue;
      out_data_in[68:5]    = issue ? st_dest_ff : 64'd0;
      out_data_in[100:69]  = issue ? st_length_ff : 32'd0;
      out_data_in[108:101] = issue ? st_fill_byte_ff : 8'd0;
      out_data_in[110:109] = wb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Checks
   `ASSERT_IMPLIES(a_irq_onehot, clock, reset, 1'b1, $onehot0(irq_ff))
   `ASSERT_IMPLIES(a_done_irq_status, clock, reset,
      irq_ff[msda_pkg::IRQ_DONE_IDX], status_ff == msda_pkg::ST_DONE)
   `ASSERT_IMPLIES(a_err_irq_status, clock, reset,
      irq_ff[msda_pkg::IRQ_ERROR_IDX], status_ff == msda_pkg::ST_ERROR)
   `ASSERT_IMPLIES(a_issue_ok, clock, reset, out_valid_ff && out_data_ff[4],
      (out_data_ff[110:109] == msda_pkg::WB_OK) && (out_data_ff[1:0] == msda_pkg::ST_DONE))
   `ASSERT_NEXT(a_soft_reset, clock, reset, advance && st_reset_ff,
      (status_ff == msda_pkg::ST_IDLE) && (irq_ff == 2'b00))

endmodule
